// ===== rtl/core/homing_step_toward_target_top_macros.svh =====
// assertion macros for the homing step checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef HOMING_STEP_TOWARD_TARGET_TOP_MACROS_SVH
`define HOMING_STEP_TOWARD_TARGET_TOP_MACROS_SVH

// same-cycle implication
`define HST_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("homing step check failed");

// next-cycle implication, consequent may be a sequence
`define HST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error("homing step check failed");

`endif

// ===== rtl/core/hst_pkg.sv =====
// shared types and constants of the homing step block
// no dependencies
package hst_pkg;

    localparam int COORD_W    = 32;
    localparam int SPEED_W    = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MAG_W      = COORD_W + 1;
    localparam int NORM_W     = 31;
    localparam int PROD_W     = 2 * NORM_W;
    localparam int ACC_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int SUM_W      = COORD_W + 2;
    localparam int ITER_N     = 32;
    localparam int CNT_W      = $clog2(ITER_N);
    localparam int NUM_AX     = 3;
    localparam int AX_W       = 2;

    localparam int SPEED_RST_INT  = 5;
    localparam int RADIUS_RST_INT = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_Z  = 3'd4;

    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_CHK,
        S_NORM,
        S_SQ,
        S_ACC,
        S_SQRT_GO,
        S_SQRT,
        S_MUL,
        S_DIV_GO,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic {
        RD_SQRT,
        RD_DIV
    } t_rd_op;

    typedef struct packed {
        logic   start;
        t_rd_op op;
    } t_rd_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rd_sts;

endpackage

// ===== rtl/core/hst_in_if.sv =====
// input channel of the homing step block: mode and load position
// depends on hst_pkg
interface hst_in_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic signed [hst_pkg::COORD_W-1:0] load_x;
    logic signed [hst_pkg::COORD_W-1:0] load_y;
    logic signed [hst_pkg::COORD_W-1:0] load_z;

    modport source (output valid, mode, load_x, load_y, load_z, input ready);
    modport sink (input valid, mode, load_x, load_y, load_z, output ready);
endinterface

// ===== rtl/core/hst_out_if.sv =====
// result channel of the homing step block: position and flags
// depends on hst_pkg
interface hst_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [hst_pkg::COORD_W-1:0] pos_x;
    logic signed [hst_pkg::COORD_W-1:0] pos_y;
    logic signed [hst_pkg::COORD_W-1:0] pos_z;
    logic                               arrived;
    logic                               saturated;

    modport source (output valid, pos_x, pos_y, pos_z, arrived, saturated, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, arrived, saturated, output ready);
endinterface

// ===== rtl/core/hst_cfg_if.sv =====
// configuration write channel of the homing step block
// depends on hst_pkg
interface hst_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [hst_pkg::CFG_IDX_W-1:0]     index;
    logic [hst_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/hst_root_div.sv =====
// shared shift-subtract unit: 64-bit integer square root or 64/32 divide
// one result bit per cycle, 32 iterations; depends on hst_pkg
module hst_root_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hst_pkg::t_rd_ctl             i_ctl,
    input  logic [hst_pkg::ACC_W-1:0]    i_rad,
    input  logic [hst_pkg::ROOT_W-1:0]   i_den,
    output hst_pkg::t_rd_sts             o_sts,
    output logic [hst_pkg::ROOT_W-1:0]   o_res
);
    import hst_pkg::*;

    localparam logic [ACC_W-1:0] BIT0 = ACC_W'(1) << (ACC_W - 2);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_rd_op           r_op;
    logic [ACC_W-1:0] r_a;
    logic [ACC_W-1:0] r_b;
    logic [ACC_W-1:0] r_bit;

    logic [ROOT_W:0]  w_rem_sh;
    logic [ACC_W-1:0] w_sub_a;
    logic [ACC_W-1:0] w_sub_b;
    logic [ACC_W:0]   w_diff;
    logic             w_ge;

    assign w_rem_sh = {r_a[ROOT_W-1:0], r_b[ACC_W-1]};
    assign w_sub_a  = (r_op == RD_SQRT) ? r_a : ACC_W'(w_rem_sh);
    assign w_sub_b  = (r_op == RD_SQRT) ? (r_b | r_bit) : ACC_W'(i_den);
    assign w_diff   = {1'b0, w_sub_a} - {1'b0, w_sub_b};
    assign w_ge     = !w_diff[ACC_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ITER_N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op  <= i_ctl.op;
            r_bit <= BIT0;
            if (i_ctl.op == RD_SQRT) begin
                r_a <= i_rad;
                r_b <= '0;
            end else begin
                r_a <= ACC_W'(i_rad[ACC_W-1:ROOT_W]);
                r_b <= {i_rad[ROOT_W-1:0], {(ACC_W-ROOT_W){1'b0}}};
            end
        end else if (r_busy) begin
            if (r_op == RD_SQRT) begin
                r_bit <= r_bit >> 2;
                if (w_ge) begin
                    r_a <= w_diff[ACC_W-1:0];
                    r_b <= (r_b >> 1) | r_bit;
                end else begin
                    r_b <= r_b >> 1;
                end
            end else begin
                r_b <= {r_b[ACC_W-2:0], w_ge};
                if (w_ge) begin
                    r_a <= ACC_W'(w_diff[ROOT_W-1:0]);
                end else begin
                    r_a <= ACC_W'(w_rem_sh[ROOT_W-1:0]);
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_res      = r_b[ROOT_W-1:0];

endmodule

// ===== rtl/core/homing_step_toward_target_top.sv =====
// homing step: a load goes to the output register, an arriving tick stops after the box test,
// a moving tick then normalizes and runs one 32-step root and three 32-step divides
// on the shared shift-subtract unit; one item in flight, input not ready meanwhile
// the result register frees the input side while a result waits to be taken
// reset: synchronous active low, clears position and control, restores config defaults
module homing_step_toward_target_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hst_in_if.sink    i_in,
    hst_out_if.source o_out,
    hst_cfg_if.sink   i_cfg
);
    import hst_pkg::*;

    localparam logic [SPEED_W-1:0] SPEED_RST  = SPEED_W'(SPEED_RST_INT << FRAC_BITS);
    localparam logic [SPEED_W-1:0] RADIUS_RST = SPEED_W'(RADIUS_RST_INT << FRAC_BITS);
    localparam logic [AX_W-1:0]    AX_LAST    = AX_W'(NUM_AX - 1);

    t_state r_state;
    t_state n_state;

    logic [SPEED_W-1:0] r_speed;
    logic [SPEED_W-1:0] r_radius;
    logic [COORD_W-1:0] r_tgt [NUM_AX];
    logic [COORD_W-1:0] r_pos [NUM_AX];

    logic [AX_W-1:0]    r_ax;
    logic [MAG_W-1:0]   r_e [NUM_AX];
    logic [NUM_AX-1:0]  r_dneg;
    logic [MAG_W-1:0]   r_m;
    logic               r_far;
    logic [PROD_W-1:0]  r_prod;
    logic [ACC_W-1:0]   r_acc;
    logic [ROOT_W-1:0]  r_len;
    logic               r_arr;
    logic               r_sat;

    logic               r_ov;
    logic [COORD_W-1:0] r_out_pos [NUM_AX];
    logic               r_out_arr;
    logic               r_out_sat;

    logic               w_in_acc;
    logic               w_out_free;
    logic [COORD_W-1:0] w_p;
    logic [COORD_W-1:0] w_t;
    logic [MAG_W-1:0]   w_d;
    logic [MAG_W-1:0]   w_e;
    logic               w_near;
    logic [NORM_W-1:0]  w_mul_a;
    logic [NORM_W-1:0]  w_mul_b;
    logic [PROD_W-1:0]  w_prod;
    logic [SUM_W-1:0]   w_stp;
    logic [SUM_W-1:0]   w_sum;
    logic               w_ovf;
    logic [COORD_W-1:0] w_new;
    logic               w_big;

    t_rd_ctl            w_ctl;
    t_rd_sts            u_sts;
    logic [ACC_W-1:0]   w_rad;
    logic [ROOT_W-1:0]  u_res;

    hst_root_div u_rd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_rad   (w_rad),
        .i_den   (r_len),
        .o_sts   (u_sts),
        .o_res   (u_res)
    );

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_ov || o_out.ready;

    // per-axis difference and box test
    assign w_p    = r_pos[r_ax];
    assign w_t    = r_tgt[r_ax];
    assign w_d    = {w_t[COORD_W-1], w_t} - {w_p[COORD_W-1], w_p};
    assign w_e    = w_d[MAG_W-1] ? (~w_d + 1'b1) : w_d;
    assign w_near = (w_e <= MAG_W'(r_radius));
    assign w_big  = |r_m[MAG_W-1:NORM_W];

    // shared multiplier: squares, then speed times magnitude
    assign w_mul_a = r_e[r_ax][NORM_W-1:0];
    assign w_mul_b = (r_state == S_SQ) ? w_mul_a : r_speed;
    assign w_prod  = w_mul_a * w_mul_b;

    // signed step and saturating add
    assign w_stp = r_dneg[r_ax] ? (~SUM_W'(u_res) + 1'b1) : SUM_W'(u_res);
    assign w_sum = {{2{w_p[COORD_W-1]}}, w_p} + w_stp;
    assign w_ovf = (w_sum[SUM_W-1:COORD_W-1] != 3'b000)
                && (w_sum[SUM_W-1:COORD_W-1] != 3'b111);
    assign w_new = w_ovf ? (w_sum[SUM_W-1] ? COORD_MIN : COORD_MAX)
                         : w_sum[COORD_W-1:0];

    assign w_ctl.start = (r_state == S_SQRT_GO) || (r_state == S_DIV_GO);
    assign w_ctl.op    = (r_state == S_SQRT_GO) ? RD_SQRT : RD_DIV;
    assign w_rad       = (r_state == S_SQRT_GO) ? r_acc
                       : ACC_W'(r_prod) + ACC_W'(r_len[ROOT_W-1:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = i_in.mode ? S_DONE : S_DIFF;
                end
            end
            S_DIFF: begin
                if (r_ax == AX_LAST) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = r_far ? S_NORM : S_DONE;
            end
            S_NORM: begin
                if (w_big || r_m[NORM_W-1]) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_state = (r_ax == AX_LAST) ? S_SQRT_GO : S_SQ;
            end
            S_SQRT_GO: begin
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (u_sts.done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (u_sts.done) begin
                    n_state = (r_ax == AX_LAST) ? S_DONE : S_MUL;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // config registers and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed  <= SPEED_RST;
            r_radius <= RADIUS_RST;
            r_tgt[0] <= '0;
            r_tgt[1] <= '0;
            r_tgt[2] <= '0;
            r_pos[0] <= '0;
            r_pos[1] <= '0;
            r_pos[2] <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_SPEED:  r_speed  <= i_cfg.data[SPEED_W-1:0];
                    CFG_RADIUS: r_radius <= i_cfg.data[SPEED_W-1:0];
                    CFG_TGT_X:  r_tgt[0] <= i_cfg.data;
                    CFG_TGT_Y:  r_tgt[1] <= i_cfg.data;
                    CFG_TGT_Z:  r_tgt[2] <= i_cfg.data;
                    default: ;
                endcase
            end
            if (w_in_acc && i_in.mode) begin
                r_pos[0] <= i_in.load_x;
                r_pos[1] <= i_in.load_y;
                r_pos[2] <= i_in.load_z;
            end else if (r_state == S_DIV && u_sts.done) begin
                r_pos[r_ax] <= w_new;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ax  <= '0;
                r_m   <= '0;
                r_far <= 1'b0;
                r_arr <= 1'b0;
                r_sat <= 1'b0;
            end
            S_DIFF: begin
                r_e[r_ax]    <= w_e;
                r_dneg[r_ax] <= w_d[MAG_W-1];
                r_far        <= r_far || !w_near;
                if (w_e > r_m) begin
                    r_m <= w_e;
                end
                r_ax <= (r_ax == AX_LAST) ? '0 : r_ax + 1'b1;
            end
            S_CHK: begin
                r_arr <= !r_far;
                r_acc <= '0;
            end
            S_NORM: begin
                if (w_big) begin
                    for (int i = 0; i < NUM_AX; i++) begin
                        r_e[i] <= r_e[i] >> 1;
                    end
                end else if (!r_m[NORM_W-1]) begin
                    r_m <= r_m << 1;
                    for (int i = 0; i < NUM_AX; i++) begin
                        r_e[i] <= r_e[i] << 1;
                    end
                end
            end
            S_SQ: begin
                r_prod <= w_prod;
            end
            S_ACC: begin
                r_acc <= r_acc + ACC_W'(r_prod);
                r_ax  <= (r_ax == AX_LAST) ? '0 : r_ax + 1'b1;
            end
            S_SQRT: begin
                if (u_sts.done) begin
                    r_len <= u_res;
                end
            end
            S_MUL: begin
                r_prod <= w_prod;
            end
            S_DIV: begin
                if (u_sts.done) begin
                    r_sat <= r_sat || w_ovf;
                    r_ax  <= (r_ax == AX_LAST) ? '0 : r_ax + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_pos[0] <= r_pos[0];
            r_out_pos[1] <= r_pos[1];
            r_out_pos[2] <= r_pos[2];
            r_out_arr    <= r_arr;
            r_out_sat    <= r_sat;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.pos_x     = r_out_pos[0];
    assign o_out.pos_y     = r_out_pos[1];
    assign o_out.pos_z     = r_out_pos[2];
    assign o_out.arrived   = r_out_arr;
    assign o_out.saturated = r_out_sat;

endmodule

// ===== rtl/core/hst_checker.sv =====
// port-level checks for homing_step_toward_target_top, attached by bind
// depends on hst_pkg and homing_step_toward_target_top_macros.svh
`include "homing_step_toward_target_top_macros.svh"

module hst_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_in_mode,
    input logic [hst_pkg::COORD_W-1:0]  i_in_load_x,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [hst_pkg::COORD_W-1:0]  i_out_pos_x,
    input logic                         i_out_arrived,
    input logic                         i_out_saturated
);
    import hst_pkg::*;

    // busy after every accepted beat
    `HST_ASSERT_NEXT(a_busy_after_beat, i_in_valid && i_in_ready, !i_in_ready)
    // a stalled result beat holds
    `HST_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
                     (i_out_valid && $stable(i_out_pos_x)))
    // a load beat into a free result slot passes the done state and the result register, then shows up
    `HST_ASSERT_NEXT(a_load_result,
                     i_in_valid && i_in_ready && i_in_mode && !i_out_valid,
                     ##1 (i_out_valid && i_out_pos_x == $past(i_in_load_x, 2)
                          && !i_out_arrived && !i_out_saturated))
    // a new result only comes out of a busy block
    `HST_ASSERT_SAME(a_result_from_busy, $rose(i_out_valid), !$past(i_in_ready))

endmodule

bind homing_step_toward_target_top hst_checker u_hst_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_mode       (i_in.mode),
    .i_in_load_x     (i_in.load_x),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_pos_x     (o_out.pos_x),
    .i_out_arrived   (o_out.arrived),
    .i_out_saturated (o_out.saturated)
);

// ===== test/tb.sv =====
// testbench for homing_step_toward_target_top: loads, ticks and register writes
// predicts each position beat and compares it with the result channel
// depends on hst_pkg, hst_in_if, hst_out_if, hst_cfg_if and the top level
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hst_pkg::*;

    localparam int     FRAC          = 16;
    localparam logic   MODE_TICK     = 1'b0;
    localparam logic   MODE_LOAD     = 1'b1;
    localparam longint LIM_HI        = 64'sd2147483647;
    localparam longint LIM_LO        = -64'sd2147483648;
    localparam int     LIMIT_CYCLES  = 2_000_000;
    localparam int     RAND_PHASES   = 10;
    localparam int     PHASE_ITEMS   = 145;
    localparam int     DRAIN_CYCLES  = 200;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      arrived;
        logic                      saturated;
    } t_pos_beat;

    class step_checker;
        bit [SPEED_W-1:0]          speed;
        bit [SPEED_W-1:0]          radius;
        logic signed [COORD_W-1:0] tgt[3];
        logic signed [COORD_W-1:0] pos[3];
        t_pos_beat                 due_positions[$];
        int                        errors;
        int                        checked;
        int                        arrivals;
        int                        saturations;

        function new();
            speed  = SPEED_W'(SPEED_RST_INT << FRAC);
            radius = SPEED_W'(RADIUS_RST_INT << FRAC);
            foreach (tgt[i]) begin
                tgt[i] = '0;
                pos[i] = '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SPEED:  speed  = data[SPEED_W-1:0];
                CFG_RADIUS: radius = data[SPEED_W-1:0];
                CFG_TGT_X:  tgt[0] = data;
                CFG_TGT_Y:  tgt[1] = data;
                CFG_TGT_Z:  tgt[2] = data;
                default: ;
            endcase
        endfunction

        function bit [63:0] floor_root(bit [63:0] n);
            bit [63:0] root;
            bit [63:0] b;
            root = '0;
            b = 64'd1 << 62;
            while (b > n)
                b >>= 2;
            while (b != 0) begin
                if (n >= root + b) begin
                    n -= root + b;
                    root = (root >> 1) + b;
                end else begin
                    root >>= 1;
                end
                b >>= 2;
            end
            return root;
        endfunction

        function void predict_position(input logic mode,
                                       input logic signed [COORD_W-1:0] lx, ly, lz);
            t_pos_beat want;
            longint    d[3];
            bit [63:0] e[3];
            bit [63:0] top;
            bit [63:0] len;
            bit [63:0] q;
            longint    r;
            bit        in_box;
            want.arrived   = 1'b0;
            want.saturated = 1'b0;
            in_box = 1'b1;
            top = '0;
            if (mode == MODE_LOAD) begin
                pos[0] = lx;
                pos[1] = ly;
                pos[2] = lz;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    d[i] = longint'(tgt[i]) - longint'(pos[i]);
                    e[i] = (d[i] < 0) ? -d[i] : d[i];
                    if (e[i] > radius)
                        in_box = 1'b0;
                    if (e[i] > top)
                        top = e[i];
                end
                if (in_box) begin
                    want.arrived = 1'b1;
                    arrivals++;
                end else begin
                    // bring the largest magnitude into [2^30, 2^31)
                    if (top >= 64'h8000_0000) begin
                        foreach (e[i])
                            e[i] >>= 1;
                    end else begin
                        while (top < 64'h4000_0000) begin
                            top <<= 1;
                            foreach (e[i])
                                e[i] <<= 1;
                        end
                    end
                    len = floor_root(e[0] * e[0] + e[1] * e[1] + e[2] * e[2]);
                    for (int i = 0; i < 3; i++) begin
                        q = (64'(speed) * e[i] + (len >> 1)) / len;
                        r = longint'(pos[i]) + ((d[i] < 0) ? -longint'(q) : longint'(q));
                        if (r > LIM_HI) begin
                            pos[i] = COORD_MAX;
                            want.saturated = 1'b1;
                        end else if (r < LIM_LO) begin
                            pos[i] = COORD_MIN;
                            want.saturated = 1'b1;
                        end else begin
                            pos[i] = r[COORD_W-1:0];
                        end
                    end
                    if (want.saturated)
                        saturations++;
                end
            end
            want.pos_x = pos[0];
            want.pos_y = pos[1];
            want.pos_z = pos[2];
            due_positions.push_back(want);
        endfunction

        function void cmp_field(string name, logic signed [COORD_W-1:0] want,
                                logic signed [COORD_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_position(t_pos_beat got);
            t_pos_beat want;
            if (due_positions.size() == 0) begin
                $error("result beat with no item waiting: pos %0d %0d %0d",
                       got.pos_x, got.pos_y, got.pos_z);
                errors++;
                return;
            end
            want = due_positions.pop_front();
            checked++;
            cmp_field("pos_x", want.pos_x, got.pos_x);
            cmp_field("pos_y", want.pos_y, got.pos_y);
            cmp_field("pos_z", want.pos_z, got.pos_z);
            cmp_field("arrived", COORD_W'(want.arrived), COORD_W'(got.arrived));
            cmp_field("saturated", COORD_W'(want.saturated), COORD_W'(got.saturated));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hst_in_if  in_ch ();
    hst_out_if out_ch ();
    hst_cfg_if cfg_ch ();

    homing_step_toward_target_top #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    step_checker sb = new();
    bit          steady = 1'b0;
    int          hold_cycles = 0;
    int          cycles = 0;
    int          items_sent = 0;
    int          loads_sent = 0;
    int          reg_writes = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure
    always @(negedge i_clk) begin
        if (hold_cycles != 0) begin
            hold_cycles = hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 99) < 30) begin
            hold_cycles = gap_len() - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_pos_beat got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.pos_x     = out_ch.pos_x;
            got.pos_y     = out_ch.pos_y;
            got.pos_z     = out_ch.pos_z;
            got.arrived   = out_ch.arrived;
            got.saturated = out_ch.saturated;
            sb.check_position(got);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_item(input logic mode, input logic signed [COORD_W-1:0] x, y, z);
        int gap;
        gap = (steady || $urandom_range(0, 99) < 55) ? 0 : gap_len();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.mode   <= mode;
        in_ch.load_x <= x;
        in_ch.load_y <= y;
        in_ch.load_z <= z;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        sb.predict_position(mode, x, y, z);
        items_sent++;
        if (mode == MODE_LOAD)
            loads_sent++;
    endtask

    task automatic tick();
        send_item(MODE_TICK, $urandom, $urandom, $urandom);
    endtask

    task automatic lower_valid();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.due_positions.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        sb.set_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_target();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return COORD_MAX;
            2: return COORD_MIN;
            3: return {{12{v[31]}}, v[19:0]};
            default: return v;
        endcase
    endfunction

    task automatic pick_config(input int p);
        logic [CFG_DATA_W-1:0] spd;
        logic [CFG_DATA_W-1:0] rad;
        case ($urandom_range(0, 7))
            0: spd = '0;
            1: spd = '1;
            2: spd = $urandom_range(1, 255);
            3: spd = SPEED_RST_INT << FRAC;
            4: spd = $urandom_range(1 << FRAC, 64 << FRAC);
            5: spd = $urandom_range(1 << 12, 1 << 20);
            default: spd = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0: rad = '0;
            1: rad = '1;
            2: rad = RADIUS_RST_INT << FRAC;
            3: rad = $urandom_range(0, 16 << FRAC);
            default: rad = $urandom;
        endcase
        if (p == 0) begin
            spd = '0;
        end else if (p == 1) begin
            spd = '1;
            rad = '1;
        end else if (p == 2) begin
            spd = 1;
            rad = '0;
        end
        write_reg(CFG_SPEED, spd);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_TGT_X, pick_target());
        write_reg(CFG_TGT_Y, pick_target());
        write_reg(CFG_TGT_Z, pick_target());
        // unmapped indexes must leave every register alone
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_TGT_Z + 3'($urandom_range(1, 3)), $urandom);
    endtask

    // mostly near the target so ticks reach the box, some anywhere
    function automatic logic signed [COORD_W-1:0] near_coord(int ax);
        logic [31:0] r;
        longint      span;
        longint      v;
        bit [63:0]   raw;
        r = $urandom;
        case ($urandom_range(0, 9))
            6, 7: v = longint'(signed'(r));
            8: begin
                case (r[1:0])
                    2'd0: v = LIM_HI;
                    2'd1: v = LIM_LO;
                    2'd2: v = 0;
                    default: v = -1;
                endcase
            end
            9: v = longint'(sb.tgt[ax]) + (r[0] ? 1 : -1) *
                   (longint'(sb.radius) + longint'(r[1]));
            default: begin
                span = longint'(sb.speed) * 4 + longint'(sb.radius) * 2 + 16;
                raw  = {$urandom, $urandom} % 64'(2 * span + 1);
                v    = longint'(sb.tgt[ax]) + longint'(raw) - span;
            end
        endcase
        if (v > LIM_HI)
            v = LIM_HI;
        if (v < LIM_LO)
            v = LIM_LO;
        return v[COORD_W-1:0];
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_TICK;
        in_ch.load_x  = '0;
        in_ch.load_y  = '0;
        in_ch.load_z  = '0;
        out_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_SPEED;
        cfg_ch.data   = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: arrival at origin, both normalize directions, box edge
        tick();
        send_item(MODE_LOAD, COORD_MAX, COORD_MIN, '0);
        tick();
        tick();
        send_item(MODE_LOAD, 32'sh0002_0001, '0, '0);
        tick();
        tick();
        send_item(MODE_LOAD, 32'sh0002_0000, -32'sh0002_0000, 32'sh0002_0000);
        tick();
        send_item(MODE_LOAD, COORD_MIN, COORD_MIN, COORD_MIN);
        tick();
        lower_valid();
        wait_drained();

        // full speed, zero radius, x and y targets on the coordinate limits, z target at zero
        write_reg(CFG_SPEED, '1);
        write_reg(CFG_RADIUS, '0);
        write_reg(CFG_TGT_X, COORD_MAX);
        write_reg(CFG_TGT_Y, COORD_MIN);
        write_reg(CFG_TGT_Z, '0);
        send_item(MODE_LOAD, COORD_MAX - 32'h1_0000, COORD_MIN + 32'h1_0000, '0);
        tick();
        tick();
        send_item(MODE_LOAD, COORD_MAX, COORD_MIN, 32'sd1);
        tick();
        send_item(MODE_LOAD, '0, '0, '0);
        tick();
        tick();
        lower_valid();

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            pick_config(p);
            steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 11) == 0)
                    send_item(MODE_LOAD, near_coord(0), near_coord(1), near_coord(2));
                else
                    tick();
            end
            lower_valid();
        end

        steady = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d items (%0d loads) over %0d register writes, %0d results checked",
                 items_sent, loads_sent, reg_writes, sb.checked);
        $display("%0d ticks stopped in the arrival box, %0d moves hit a coordinate limit",
                 sb.arrivals, sb.saturations);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
